// ----- rtl/core/phs_pkg.sv -----
// Package for the Phong specular term: widths, register indexes, side-band types
// and the arithmetic helpers shared by the datapath. No dependencies.
`default_nettype none
package phs_pkg;

  localparam int unsigned SHINE_EXPONENT_DEF = 32;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned BRT_W     = 17;
  localparam int unsigned LVL_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [BRT_W-1:0] BRIGHT_RESET = 17'h10000;
  localparam logic [16:0]      ONE_Q16      = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X = 3'd0,
    CFG_LIGHT_Y = 3'd1,
    CFG_LIGHT_Z = 3'd2,
    CFG_BRIGHT  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][DIR_W-1:0]  n;
    logic [2:0][DIR_W-1:0]  v;
  } side_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
    sq_t         o;
    logic [35:0] rs;
    logic [35:0] t;
    rs = {s.rem[33:0], pair};
    t  = {2'b00, s.root, 2'b01};
    if (rs >= t) begin
      o.rem  = rs - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [16:0] qmul16(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd32768;
    return p[32:16];
  endfunction

  // divide by 2^27, round half away from zero
  function automatic logic signed [23:0] rnd27(input logic signed [49:0] t);
    logic [49:0] mag;
    logic [49:0] m;
    mag = t[49] ? 50'(-t) : 50'(t);
    m   = (mag + 50'h4000000) >> 27;
    return t[49] ? -$signed(m[23:0]) : $signed(m[23:0]);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/phs_in_if.sv -----
// Shading request channel: hit point, normal and view direction with valid/ready.
// Depends on phs_pkg for field widths.
`default_nettype none
interface phs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [phs_pkg::POS_W-1:0]    hit_x;
  logic signed [phs_pkg::POS_W-1:0]    hit_y;
  logic signed [phs_pkg::POS_W-1:0]    hit_z;
  logic signed [phs_pkg::DIR_W-1:0]    normal_x;
  logic signed [phs_pkg::DIR_W-1:0]    normal_y;
  logic signed [phs_pkg::DIR_W-1:0]    normal_z;
  logic signed [phs_pkg::DIR_W-1:0]    view_x;
  logic signed [phs_pkg::DIR_W-1:0]    view_y;
  logic signed [phs_pkg::DIR_W-1:0]    view_z;

  modport source (output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  view_x, view_y, view_z, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
                  view_x, view_y, view_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/phs_out_if.sv -----
// Specular level result channel with valid/ready.
// Depends on phs_pkg for the field width.
`default_nettype none
interface phs_out_if;
  logic                          valid;
  logic                          ready;
  logic [phs_pkg::LVL_W-1:0]     specular_level;

  modport source (output valid, specular_level, input ready);
  modport sink   (input valid, specular_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/phong_specular_term.sv -----
// Phong specular term top level: full datapath from hit point to Q8.8 level.
// Depends on phs_pkg, phs_in_if and phs_out_if.
//
//   channel | direction | beat contents
//   in_ch   | in        | hit_x/y/z Q16.16, normal_x/y/z Q2.14, view_x/y/z Q2.14
//   out_ch  | out       | specular_level Q8.8
//   cfg_*   | in        | light_pos_x/y/z, light_brightness, one write per cycle
//
// One beat enters per cycle while out_ch is not holding the pipeline; the datapath
// includes the 16-stage square root (two root bits a stage) and the 15-stage divider.
// Reset clears the valid bits and loads the register defaults.
// The whole pipeline holds while a finished beat waits at out_ch; nothing drops.
`default_nettype none
module phong_specular_term #(
  parameter int unsigned SHINE_EXPONENT = phs_pkg::SHINE_EXPONENT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [phs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata,
  phs_in_if.sink                               in_ch,
  phs_out_if.source                            out_ch
);

  localparam int unsigned EW0 = $clog2(SHINE_EXPONENT + 1);
  localparam int unsigned EW  = (EW0 < 1) ? 1 : EW0;
  localparam logic [EW-1:0] EXP = EW'(SHINE_EXPONENT);
  localparam int unsigned SQ_ST = 16;
  localparam int unsigned DV_ST = 15;

  typedef struct packed {
    phs_pkg::side_t         s;
    logic [2:0][29:0]       mag;
    logic [63:0]            sum;
    phs_pkg::sq_t           sq;
  } sqp_t;

  typedef struct packed {
    phs_pkg::side_t         s;
    logic [30:0]            len;
    logic [2:0][44:0]       rem;
    logic [2:0][14:0]       q;
  } dvp_t;

  typedef struct packed {
    logic                   vld;
    logic                   kill;
    logic [16:0]            spec;
    logic [16:0]            base;
  } pwp_t;

  logic [2:0][31:0]           lp_r;
  logic [phs_pkg::BRT_W-1:0]  bright_r;

  logic ce;
  logic out_valid_r;
  logic [phs_pkg::LVL_W-1:0] out_level_r;

  assign ce           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = ce;
  assign out_ch.valid = out_valid_r;
  assign out_ch.specular_level = out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r     <= '0;
      bright_r <= phs_pkg::BRIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        phs_pkg::CFG_LIGHT_X: lp_r[0]  <= cfg_wdata;
        phs_pkg::CFG_LIGHT_Y: lp_r[1]  <= cfg_wdata;
        phs_pkg::CFG_LIGHT_Z: lp_r[2]  <= cfg_wdata;
        phs_pkg::CFG_BRIGHT:  bright_r <= cfg_wdata[phs_pkg::BRT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage A: input register
  phs_pkg::side_t   a_s_r, a_s_nxt;
  logic [2:0][31:0] a_hit_r;

  always_comb begin
    a_s_nxt      = '0;
    a_s_nxt.vld  = in_ch.valid;
    a_s_nxt.n[0] = in_ch.normal_x;
    a_s_nxt.n[1] = in_ch.normal_y;
    a_s_nxt.n[2] = in_ch.normal_z;
    a_s_nxt.v[0] = in_ch.view_x;
    a_s_nxt.v[1] = in_ch.view_y;
    a_s_nxt.v[2] = in_ch.view_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_s_r.vld <= 1'b0;
    end else if (ce) begin
      a_s_r   <= a_s_nxt;
      a_hit_r <= {in_ch.hit_z, in_ch.hit_y, in_ch.hit_x};
    end
  end

  // stage B: difference and magnitudes
  phs_pkg::side_t   b_s_r, b_s_nxt;
  logic [2:0][32:0] b_mag_r, b_mag_nxt;

  always_comb begin
    logic signed [32:0] d;
    b_s_nxt = a_s_r;
    for (int i = 0; i < 3; i++) begin
      d = $signed({lp_r[i][31], lp_r[i]}) - $signed({a_hit_r[i][31], a_hit_r[i]});
      b_s_nxt.neg[i] = d[32];
      b_mag_nxt[i]   = d[32] ? 33'(-d) : 33'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_s_r.vld <= 1'b0;
    end else if (ce) begin
      b_s_r   <= b_s_nxt;
      b_mag_r <= b_mag_nxt;
    end
  end

  // stage C: leading one of the largest magnitude
  phs_pkg::side_t   c_s_r, c_s_nxt;
  logic [2:0][32:0] c_mag_r;
  logic [5:0]       c_pos_r, c_pos_nxt;

  always_comb begin
    logic [32:0] orv;
    orv       = b_mag_r[0] | b_mag_r[1] | b_mag_r[2];
    c_pos_nxt = '0;
    for (int b = 0; b < 33; b++) begin
      if (orv[b]) c_pos_nxt = 6'(b);
    end
    c_s_nxt      = b_s_r;
    c_s_nxt.zero = (orv == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_s_r.vld <= 1'b0;
    end else if (ce) begin
      c_s_r   <= c_s_nxt;
      c_mag_r <= b_mag_r;
      c_pos_r <= c_pos_nxt;
    end
  end

  // stage D: scale so the largest lies in [2^29, 2^30)
  phs_pkg::side_t   d_s_r;
  logic [2:0][29:0] d_mag_r, d_mag_nxt;

  always_comb begin
    logic [32:0] m;
    for (int i = 0; i < 3; i++) begin
      if (c_pos_r >= 6'd29) m = c_mag_r[i] >> (c_pos_r - 6'd29);
      else                  m = c_mag_r[i] << (6'd29 - c_pos_r);
      d_mag_nxt[i] = m[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_s_r.vld <= 1'b0;
    end else if (ce) begin
      d_s_r   <= c_s_r;
      d_mag_r <= d_mag_nxt;
    end
  end

  // stage E: squares
  phs_pkg::side_t   e_s_r;
  logic [2:0][29:0] e_mag_r;
  logic [2:0][59:0] e_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_s_r.vld <= 1'b0;
    end else if (ce) begin
      e_s_r   <= d_s_r;
      e_mag_r <= d_mag_r;
      for (int i = 0; i < 3; i++) e_sq_r[i] <= 60'(d_mag_r[i]) * 60'(d_mag_r[i]);
    end
  end

  // square root: stage 0 loads the sum, each later stage settles two root bits
  sqp_t sqp_r [SQ_ST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqp_r[0].s.vld <= 1'b0;
    end else if (ce) begin
      sqp_r[0].s   <= e_s_r;
      sqp_r[0].mag <= e_mag_r;
      sqp_r[0].sum <= 64'(e_sq_r[0]) + 64'(e_sq_r[1]) + 64'(e_sq_r[2]);
      sqp_r[0].sq  <= '0;
    end
  end

  for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
    localparam int unsigned HI = 63 - 4 * g;
    sqp_t sqp_nxt;
    always_comb begin
      phs_pkg::sq_t t;
      sqp_nxt    = sqp_r[g];
      t          = phs_pkg::sqrt_step(sqp_r[g].sq, sqp_r[g].sum[HI -: 2]);
      sqp_nxt.sq = phs_pkg::sqrt_step(t, sqp_r[g].sum[HI-2 -: 2]);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqp_r[g+1].s.vld <= 1'b0;
      end else if (ce) begin
        sqp_r[g+1] <= sqp_nxt;
      end
    end
  end

  // divider: stage 0 forms mag*16384 + len/2, each later stage one quotient bit
  dvp_t dvp_r [DV_ST+1];

  always_ff @(posedge clk) begin
    logic [30:0] len;
    len = sqp_r[SQ_ST].sq.root[30:0];
    if (!rst_n) begin
      dvp_r[0].s.vld <= 1'b0;
    end else if (ce) begin
      dvp_r[0].s   <= sqp_r[SQ_ST].s;
      dvp_r[0].len <= len;
      dvp_r[0].q   <= '0;
      for (int i = 0; i < 3; i++) begin
        dvp_r[0].rem[i] <= {1'b0, sqp_r[SQ_ST].mag[i], 14'b0} + 45'(len >> 1);
      end
    end
  end

  for (genvar j = 0; j < DV_ST; j++) begin : g_div
    localparam int unsigned K = DV_ST - 1 - j;
    dvp_t dvp_nxt;
    always_comb begin
      logic [44:0] dl;
      dvp_nxt = dvp_r[j];
      dl      = 45'(dvp_r[j].len) << K;
      for (int i = 0; i < 3; i++) begin
        if (dvp_r[j].rem[i] >= dl) begin
          dvp_nxt.rem[i]  = dvp_r[j].rem[i] - dl;
          dvp_nxt.q[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvp_r[j+1].s.vld <= 1'b0;
      end else if (ce) begin
        dvp_r[j+1] <= dvp_nxt;
      end
    end
  end

  // P1: light direction and L*N products
  phs_pkg::side_t   p1_s_r;
  logic [2:0][15:0] p1_l_r;
  logic [2:0][31:0] p1_ln_r;

  always_ff @(posedge clk) begin
    logic signed [15:0] l;
    if (!rst_n) begin
      p1_s_r.vld <= 1'b0;
    end else if (ce) begin
      p1_s_r <= dvp_r[DV_ST].s;
      for (int i = 0; i < 3; i++) begin
        l = dvp_r[DV_ST].s.neg[i] ? -$signed({1'b0, dvp_r[DV_ST].q[i]})
                                  : $signed({1'b0, dvp_r[DV_ST].q[i]});
        p1_l_r[i]  <= l;
        p1_ln_r[i] <= 32'(l) * 32'($signed(dvp_r[DV_ST].s.n[i]));
      end
    end
  end

  // P2: L.N
  phs_pkg::side_t     p2_s_r;
  logic [2:0][15:0]   p2_l_r;
  logic signed [33:0] p2_ln_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_s_r.vld <= 1'b0;
    end else if (ce) begin
      p2_s_r  <= p1_s_r;
      p2_l_r  <= p1_l_r;
      p2_ln_r <= 34'($signed(p1_ln_r[0])) + 34'($signed(p1_ln_r[1]))
               + 34'($signed(p1_ln_r[2]));
    end
  end

  // P3: (L.N) * N
  phs_pkg::side_t   p3_s_r;
  logic [2:0][15:0] p3_l_r;
  logic [2:0][49:0] p3_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_s_r.vld <= 1'b0;
    end else if (ce) begin
      p3_s_r <= p2_s_r;
      p3_l_r <= p2_l_r;
      for (int i = 0; i < 3; i++) begin
        p3_t_r[i] <= 50'(p2_ln_r) * 50'($signed(p2_s_r.n[i]));
      end
    end
  end

  // P4: reflection
  phs_pkg::side_t   p4_s_r;
  logic [2:0][23:0] p4_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_s_r.vld <= 1'b0;
    end else if (ce) begin
      p4_s_r <= p3_s_r;
      for (int i = 0; i < 3; i++) begin
        p4_r_r[i] <= phs_pkg::rnd27($signed(p3_t_r[i])) - 24'($signed(p3_l_r[i]));
      end
    end
  end

  // P5: V*R products
  phs_pkg::side_t   p5_s_r;
  logic [2:0][39:0] p5_vr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_s_r.vld <= 1'b0;
    end else if (ce) begin
      p5_s_r <= p4_s_r;
      for (int i = 0; i < 3; i++) begin
        p5_vr_r[i] <= 40'($signed(p4_r_r[i])) * 40'($signed(p4_s_r.v[i]));
      end
    end
  end

  // P6: V.R
  phs_pkg::side_t     p6_s_r;
  logic signed [41:0] p6_vr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_s_r.vld <= 1'b0;
    end else if (ce) begin
      p6_s_r  <= p5_s_r;
      p6_vr_r <= 42'($signed(p5_vr_r[0])) + 42'($signed(p5_vr_r[1]))
               + 42'($signed(p5_vr_r[2]));
    end
  end

  // power: stage 0 takes the clipped base, stage k+1 applies exponent bit k
  pwp_t pw_r [EW+1];

  always_ff @(posedge clk) begin
    logic [41:0] xr;
    xr = (p6_vr_r + 42'sd2048) >>> 12;
    if (!rst_n) begin
      pw_r[0].vld <= 1'b0;
    end else if (ce) begin
      pw_r[0].vld  <= p6_s_r.vld;
      pw_r[0].kill <= p6_s_r.zero || (p6_vr_r <= 42'sd0);
      pw_r[0].spec <= phs_pkg::ONE_Q16;
      pw_r[0].base <= (xr > 42'd65536) ? phs_pkg::ONE_Q16 : xr[16:0];
    end
  end

  for (genvar k = 0; k < EW; k++) begin : g_pow
    pwp_t pw_nxt;
    always_comb begin
      pw_nxt      = pw_r[k];
      pw_nxt.base = phs_pkg::qmul16(pw_r[k].base, pw_r[k].base);
      if (EXP[k]) pw_nxt.spec = phs_pkg::qmul16(pw_r[k].spec, pw_r[k].base);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pw_r[k+1].vld <= 1'b0;
      end else if (ce) begin
        pw_r[k+1] <= pw_nxt;
      end
    end
  end

  // F1: spec * brightness
  logic        f1_vld_r;
  logic        f1_kill_r;
  logic [33:0] f1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (ce) begin
      f1_vld_r  <= pw_r[EW].vld;
      f1_kill_r <= pw_r[EW].kill;
      f1_m_r    <= 34'(pw_r[EW].spec) * 34'(bright_r);
    end
  end

  // output: scale by 255, round, saturate
  logic [phs_pkg::LVL_W-1:0] out_level_nxt;

  always_comb begin
    logic [41:0] y;
    y = {f1_m_r, 8'b0} - {8'b0, f1_m_r} + 42'h800000;
    if (f1_kill_r)           out_level_nxt = '0;
    else if (|y[41:40])      out_level_nxt = '1;
    else                     out_level_nxt = y[39:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= f1_vld_r;
      out_level_r <= out_level_nxt;
    end
  end

endmodule
`default_nettype wire
